// File: src/scw_pkg.sv
// Shared types, command codes and the microcode ROM of the scroll cursor window.
// Used by scw_seq and scroll_cursor_window; depends on nothing else.
`timescale 1ns / 1ps

package scw_pkg;

   localparam int POS_BITS_DEFAULT = 16;
   localparam int FIELD_BITS       = 16;
   localparam int CMD_BITS         = 3;
   localparam int CSR_INDEX_BITS   = 3;

   // Command codes of the request beat.
   localparam logic [CMD_BITS-1:0] CMD_HOME      = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_END       = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_UP        = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_DOWN      = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_PAGE_UP   = 3'd4;
   localparam logic [CMD_BITS-1:0] CMD_PAGE_DOWN = 3'd5;
   localparam logic [CMD_BITS-1:0] CMD_GO        = 3'd6;
   localparam logic [CMD_BITS-1:0] CMD_NOP       = 3'd7;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] REG_LIST_MIN    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LIST_MAX    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LIST_SIZE   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PAGE_SIZE   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WRAP_ENABLE = 3'd4;

   // Datapath operations.
   localparam int OP_BITS = 3;
   localparam logic [OP_BITS-1:0] OP_NOP      = 3'd0;
   localparam logic [OP_BITS-1:0] OP_MOVE     = 3'd1;
   localparam logic [OP_BITS-1:0] OP_CLAMP    = 3'd2;
   localparam logic [OP_BITS-1:0] OP_ZERO_TOP = 3'd3;
   localparam logic [OP_BITS-1:0] OP_DIV_INIT = 3'd4;
   localparam logic [OP_BITS-1:0] OP_DIV_STEP = 3'd5;
   localparam logic [OP_BITS-1:0] OP_ALIGN    = 3'd6;
   localparam logic [OP_BITS-1:0] OP_COMMIT   = 3'd7;

   // Jump conditions.
   localparam int COND_BITS = 3;
   localparam logic [COND_BITS-1:0] COND_NEXT     = 3'd0;
   localparam logic [COND_BITS-1:0] COND_INACTIVE = 3'd1;
   localparam logic [COND_BITS-1:0] COND_INSIDE   = 3'd2;
   localparam logic [COND_BITS-1:0] COND_PS_ZERO  = 3'd3;
   localparam logic [COND_BITS-1:0] COND_DIV_MORE = 3'd4;

   // Program step addresses.
   localparam int STEP_BITS = 4;
   localparam logic [STEP_BITS-1:0] S_CHECK    = 4'd0;
   localparam logic [STEP_BITS-1:0] S_MOVE     = 4'd1;
   localparam logic [STEP_BITS-1:0] S_CLAMP    = 4'd2;
   localparam logic [STEP_BITS-1:0] S_TEST     = 4'd3;
   localparam logic [STEP_BITS-1:0] S_ZERO_TOP = 4'd4;
   localparam logic [STEP_BITS-1:0] S_DIV_INIT = 4'd5;
   localparam logic [STEP_BITS-1:0] S_DIV_STEP = 4'd6;
   localparam logic [STEP_BITS-1:0] S_ALIGN    = 4'd7;
   localparam logic [STEP_BITS-1:0] S_COMMIT   = 4'd8;

   typedef struct packed {
      logic [OP_BITS-1:0]   op;
      logic [COND_BITS-1:0] cond;
      logic [STEP_BITS-1:0] target;
      logic                 last;
   } uword_type;

   typedef struct packed {
      logic inactive;
      logic on_page;
      logic ps_zero;
      logic div_more;
      logic out_hold;
   } flags_type;

   typedef struct packed {
      uword_type word;
      logic      busy;
      logic      fire;
   } ctrl_type;

   function automatic uword_type ucode_rom(logic [STEP_BITS-1:0] step);
      uword_type w;
      unique case (step)
         S_CHECK:    w = '{op: OP_NOP,      cond: COND_INACTIVE, target: S_COMMIT,   last: 1'b0};
         S_MOVE:     w = '{op: OP_MOVE,     cond: COND_NEXT,     target: S_CHECK,    last: 1'b0};
         S_CLAMP:    w = '{op: OP_CLAMP,    cond: COND_NEXT,     target: S_CHECK,    last: 1'b0};
         S_TEST:     w = '{op: OP_NOP,      cond: COND_INSIDE,   target: S_COMMIT,   last: 1'b0};
         S_ZERO_TOP: w = '{op: OP_ZERO_TOP, cond: COND_PS_ZERO,  target: S_COMMIT,   last: 1'b0};
         S_DIV_INIT: w = '{op: OP_DIV_INIT, cond: COND_NEXT,     target: S_CHECK,    last: 1'b0};
         S_DIV_STEP: w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE, target: S_DIV_STEP, last: 1'b0};
         S_ALIGN:    w = '{op: OP_ALIGN,    cond: COND_NEXT,     target: S_CHECK,    last: 1'b0};
         default:    w = '{op: OP_COMMIT,   cond: COND_NEXT,     target: S_CHECK,    last: 1'b1};
      endcase
      return w;
   endfunction

endpackage

// File: src/scw_seq.sv
// Microcode sequencer of the scroll cursor window: step counter, ROM fetch and jumps.
// Depends on scw_pkg for the control word, the flag struct and the ROM contents.
`timescale 1ns / 1ps

module scw_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  scw_pkg::flags_type  flags,
   output scw_pkg::ctrl_type   ctrl
);
   import scw_pkg::*;

   logic                 busy_ff, busy_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   uword_type            word;
   logic                 taken;
   logic                 fire;

   assign word = ucode_rom(step_ff);
   // The final step waits while the previous result still sits in the output register.
   assign fire = busy_ff && !(word.last && flags.out_hold);

   always_comb begin
      unique case (word.cond)
         COND_NEXT:     taken = 1'b0;
         COND_INACTIVE: taken = flags.inactive;
         COND_INSIDE:   taken = flags.on_page;
         COND_PS_ZERO:  taken = flags.ps_zero;
         COND_DIV_MORE: taken = flags.div_more;
         default:       taken = 1'b0;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            step_in = S_CHECK;
         end
      end else if (fire) begin
         if (word.last) begin
            busy_in = 1'b0;
            step_in = S_CHECK;
         end else if (taken) begin
            step_in = word.target;
         end else begin
            step_in = step_ff + STEP_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= S_CHECK;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   assign ctrl.word = word;
   assign ctrl.busy = busy_ff;
   assign ctrl.fire = fire;

endmodule

// File: src/scroll_cursor_window.sv
// Top level of the scroll cursor window: request and result channels, registers and datapath.
// Depends on scw_pkg and on scw_seq, which steps the microprogram.
`timescale 1ns / 1ps

// The block holds a cursor and the top of the visible page over a list bounded by list_min and
// list_max, and answers every request beat with one result beat carrying both after the command.
// A request is taken whenever the block is not busy; the command then runs as a short microcode
// program on a shared datapath, starting the cycle after the beat. A NOP, or a command other than
// GO on an empty list, goes straight to the commit step; one that leaves the cursor on its page
// skips the realignment, and one with page_size 0 sets the page top to zero instead. Otherwise
// the page top is found by a restoring divider that retires one quotient bit a cycle. The result
// sits in an output register, so a new request is taken while it waits; the next result waits for
// that register to drain. Configuration is taken while idle.

module scroll_cursor_window #(
   parameter int POS_BITS = scw_pkg::POS_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [scw_pkg::CMD_BITS-1:0]        req_cmd,
   input  logic [scw_pkg::FIELD_BITS-1:0]      req_target_position,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [scw_pkg::FIELD_BITS-1:0]      rsp_cursor_position,
   output logic [scw_pkg::FIELD_BITS-1:0]      rsp_page_top_position,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [scw_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [scw_pkg::FIELD_BITS-1:0]      csr_data
);
   import scw_pkg::*;

   localparam int SW       = POS_BITS + 2;
   localparam int CNT_BITS = $clog2(POS_BITS + 1);

   typedef logic signed [SW-1:0] spos_type;

   // Configuration and architectural state.
   logic [POS_BITS-1:0] list_min_ff, list_max_ff, list_size_ff, page_size_ff;
   logic                wrap_ff;
   logic [POS_BITS-1:0] cursor_ff, cursor_in;
   logic [POS_BITS-1:0] page_top_ff, page_top_in;

   // Working registers of the datapath.
   logic [CMD_BITS-1:0] cmd_ff;
   logic [POS_BITS-1:0] tgt_ff;
   spos_type            p_ff, p_in, t_ff, t_in;
   logic [POS_BITS-1:0] rem_ff, rem_in, dvd_ff, dvd_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [POS_BITS-1:0] rsp_cur_ff, rsp_top_ff;

   flags_type flags;
   ctrl_type  ctrl;
   logic      accept, commit, csr_write;

   spos_type lo_s, hi_s, ps_s, one_s, last_vis, pm, pp, t_ps, p_c, t_c;
   logic [POS_BITS:0] trial;

   assign lo_s     = spos_type'(list_min_ff);
   assign hi_s     = spos_type'(list_max_ff);
   assign ps_s     = spos_type'(page_size_ff);
   assign one_s    = spos_type'(1);
   assign t_ps     = t_ff + ps_s;
   assign last_vis = t_ps - one_s;

   scw_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .flags (flags),
      .ctrl  (ctrl)
   );

   assign req_stall = ctrl.busy;
   assign accept    = req_valid && !ctrl.busy;
   assign csr_ready = !ctrl.busy;
   assign csr_write = csr_valid && csr_ready;
   assign commit    = ctrl.fire && (ctrl.word.op == OP_COMMIT);

   assign flags.inactive = (cmd_ff == CMD_NOP) ||
                           ((cmd_ff != CMD_GO) && (list_size_ff == '0));
   assign flags.on_page  = !((p_ff < t_ff) || (p_ff > last_vis));
   assign flags.ps_zero  = (page_size_ff == '0);
   assign flags.div_more = (cnt_ff != CNT_BITS'(1));
   assign flags.out_hold = rsp_valid_ff && rsp_stall;

   // Line moves, wrapped or clamped at the ends.
   always_comb begin
      pm = p_ff - one_s;
      if (pm < lo_s) begin
         pm = wrap_ff ? hi_s : lo_s;
      end
      pp = p_ff + one_s;
      if (pp > hi_s) begin
         pp = wrap_ff ? lo_s : hi_s;
      end
   end

   // Clamp to the minimum first, then the maximum, so inverted bounds settle at list_max.
   always_comb begin
      p_c = (p_ff < lo_s) ? lo_s : p_ff;
      p_c = (p_c > hi_s) ? hi_s : p_c;
      t_c = (t_ff < lo_s) ? lo_s : t_ff;
      t_c = (t_c > hi_s) ? hi_s : t_c;
   end

   assign trial = {rem_ff, dvd_ff[POS_BITS-1]};

   always_comb begin
      p_in   = p_ff;
      t_in   = t_ff;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         p_in = spos_type'(cursor_ff);
         t_in = spos_type'(page_top_ff);
      end else if (ctrl.fire) begin
         unique case (ctrl.word.op)
            OP_MOVE: begin
               case (cmd_ff)
                  CMD_HOME: begin
                     p_in = lo_s;
                     t_in = lo_s;
                  end
                  CMD_END: p_in = hi_s;
                  CMD_UP: begin
                     p_in = pm;
                     if (pm < t_ff) t_in = t_ff - one_s;
                  end
                  CMD_DOWN: begin
                     p_in = pp;
                     if (pp > last_vis) t_in = t_ff + one_s;
                  end
                  CMD_PAGE_UP: begin
                     p_in = (p_ff != t_ff) ? t_ff : (p_ff - ps_s);
                  end
                  CMD_PAGE_DOWN: begin
                     if (p_ff != last_vis) begin
                        p_in = last_vis;
                     end else begin
                        p_in = p_ff + ps_s;
                        if (t_ps <= hi_s) t_in = t_ps;
                     end
                  end
                  CMD_GO:  p_in = spos_type'(tgt_ff);
                  default: p_in = p_ff;
               endcase
            end
            OP_CLAMP: begin
               p_in = p_c;
               t_in = t_c;
            end
            OP_ZERO_TOP: t_in = '0;
            OP_DIV_INIT: begin
               rem_in = '0;
               dvd_in = p_ff[POS_BITS-1:0];
               cnt_in = CNT_BITS'(POS_BITS);
            end
            OP_DIV_STEP: begin
               // Restoring divide: one quotient bit per cycle, only the remainder is kept.
               if (trial >= {1'b0, page_size_ff}) begin
                  rem_in = POS_BITS'(trial - {1'b0, page_size_ff});
               end else begin
                  rem_in = trial[POS_BITS-1:0];
               end
               dvd_in = {dvd_ff[POS_BITS-2:0], 1'b0};
               cnt_in = cnt_ff - CNT_BITS'(1);
            end
            OP_ALIGN: t_in = p_ff - spos_type'(rem_ff);
            default: begin
               p_in = p_ff;
            end
         endcase
      end
   end

   always_comb begin
      cursor_in    = cursor_ff;
      page_top_in  = page_top_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (commit) begin
         cursor_in    = p_ff[POS_BITS-1:0];
         page_top_in  = t_ff[POS_BITS-1:0];
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         list_min_ff  <= '0;
         list_max_ff  <= '0;
         list_size_ff <= '0;
         page_size_ff <= POS_BITS'(1);
         wrap_ff      <= 1'b0;
         cursor_ff    <= '0;
         page_top_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cursor_ff    <= cursor_in;
         page_top_ff  <= page_top_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               REG_LIST_MIN:    list_min_ff  <= POS_BITS'(csr_data);
               REG_LIST_MAX:    list_max_ff  <= POS_BITS'(csr_data);
               REG_LIST_SIZE:   list_size_ff <= POS_BITS'(csr_data);
               REG_PAGE_SIZE:   page_size_ff <= POS_BITS'(csr_data);
               REG_WRAP_ENABLE: wrap_ff      <= csr_data[0];
               default:         wrap_ff      <= wrap_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff   <= p_in;
      t_ff   <= t_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      cnt_ff <= cnt_in;
      if (accept) begin
         cmd_ff <= req_cmd;
         tgt_ff <= POS_BITS'(req_target_position);
      end
      if (commit) begin
         rsp_cur_ff <= p_ff[POS_BITS-1:0];
         rsp_top_ff <= t_ff[POS_BITS-1:0];
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_cursor_position   = FIELD_BITS'(rsp_cur_ff);
   assign rsp_page_top_position = FIELD_BITS'(rsp_top_ff);

   // A result beat appears only after the commit step of the program.
   a_rsp_after_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(commit))
      else $error("result beat raised without a commit");

   // With ordered bounds the clamp step leaves the cursor inside them.
   a_clamp_bounds: assert property (@(posedge clock) disable iff (reset)
      (ctrl.fire && (ctrl.word.op == OP_CLAMP) && (list_min_ff <= list_max_ff))
      |=> (p_ff >= lo_s) && (p_ff <= hi_s))
      else $error("cursor outside bounds after clamp");

   // Realignment puts the cursor on the page that starts at the new top.
   a_align_page: assert property (@(posedge clock) disable iff (reset)
      (ctrl.fire && (ctrl.word.op == OP_ALIGN))
      |=> (t_ff <= p_ff) && ((p_ff - t_ff) < ps_s))
      else $error("page top realignment misses the cursor");

   // The divider never runs a step with its bit count exhausted.
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (ctrl.busy && (ctrl.word.op == OP_DIV_STEP)) |-> (cnt_ff != '0))
      else $error("divider stepped past its last bit");

endmodule
